// File: rtl/heap_sort_ascending_unit_defines.svh
// Assertion macros for the heap sort unit; clocked on clk, disabled while rst_n is low.
`ifndef HEAP_SORT_ASCENDING_UNIT_DEFINES_SVH
`define HEAP_SORT_ASCENDING_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HSA_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

`define HSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`define HSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define HSA_ASSERT(lbl, cond)

`define HSA_ASSERT_IMP(lbl, ante, cons)

`define HSA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/hsa_pkg.sv
// Shared types and constants of the heap sort unit.
package hsa_pkg;

    localparam int VALUE_W      = 32;
    localparam int CAPACITY_DEF = 64;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// File: rtl/heap_sort_ascending_unit.sv
// Batch heapsort unit: loads signed values, sorts in place, streams them out ascending.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  input     | start, busy               | value, is_last
//  result    | out_valid (one cycle)     | sorted_value, end_of_batch, dropped
//
// Loading accepts back-to-back transactions; busy stays low until is_last is accepted.
// The sort then runs on one RAM with one read and one write port: a sift level reads
// the left child, then the right child, then compares and writes; an extract step
// moves the root to the end and sifts the old end entry. Emission reads one entry per
// cycle, each result in the cycle after its read; busy is already low for the last one.
// Reset clears all control state; the element store is not cleared.
// Results cannot be stalled: each out_valid pulse is taken at the end of its cycle.
module heap_sort_ascending_unit #(
    parameter int CAPACITY = hsa_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [hsa_pkg::VALUE_W-1:0] value,
    input  logic                           is_last,
    output logic                           busy,
    output logic                           out_valid,
    output logic signed [hsa_pkg::VALUE_W-1:0] sorted_value,
    output logic                           end_of_batch,
    output logic                           dropped
);

`include "heap_sort_ascending_unit_defines.svh"

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CHW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD_NEXT,
        S_SIFT_RD,
        S_SIFT_TOP,
        S_SIFT_L,
        S_SIFT_R,
        S_SIFT_C,
        S_EX_NEXT,
        S_EX_R0,
        S_EX_R1,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   hs_reg, hs_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    hsa_pkg::value_t top_val_reg, top_val_next;
    hsa_pkg::value_t best_val_reg, best_val_next;
    logic [CW-1:0]   kcnt_reg, kcnt_next;
    logic            in_build_reg, in_build_next;
    logic [CW-1:0]   ecnt_reg, ecnt_next;
    logic            ovld_reg, ovld_next;
    logic            olast_reg, olast_next;
    logic            odrop_reg, odrop_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    hsa_pkg::value_t ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [hsa_pkg::VALUE_W-1:0] ram_rdata;

    logic [CHW-1:0]  left_w, right_w, hs_w;
    logic            left_ok, right_ok;
    logic            pick_ok;
    logic [AW-1:0]   pick_cand_idx, pick_best_idx, pick_idx;
    hsa_pkg::value_t pick_best_val, pick_val;
    logic            accept;
    logic [CW-1:0]   kcnt_dec;

    hsa_ram #(
        .WIDTH (hsa_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hsa_pick #(
        .AW (AW)
    ) u_pick (
        .cand_val (ram_rdata),
        .cand_idx (pick_cand_idx),
        .cand_ok  (pick_ok),
        .best_val (pick_best_val),
        .best_idx (pick_best_idx),
        .pick_val (pick_val),
        .pick_idx (pick_idx)
    );

    assign accept   = start && !busy;
    assign left_w   = {1'b0, idx_reg, 1'b1};
    assign right_w  = left_w + CHW'(1);
    assign hs_w     = CHW'(hs_reg);
    assign left_ok  = left_w < hs_w;
    assign right_ok = right_w < hs_w;
    assign kcnt_dec = kcnt_reg - CW'(1);

    // compare unit operands: left child against the sifted value, then right against best
    always_comb
    begin
        if (state_reg == S_SIFT_C)
        begin
            pick_cand_idx = right_w[AW-1:0];
            pick_ok       = right_ok;
            pick_best_val = best_val_reg;
            pick_best_idx = best_idx_reg;
        end
        else
        begin
            pick_cand_idx = left_w[AW-1:0];
            pick_ok       = 1'b1;
            pick_best_val = top_val_reg;
            pick_best_idx = idx_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        hs_next       = hs_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        top_val_next  = top_val_reg;
        best_val_next = best_val_reg;
        kcnt_next     = kcnt_reg;
        in_build_next = in_build_reg;
        ecnt_next     = ecnt_reg;
        ovld_next     = 1'b0;
        olast_next    = olast_reg;
        odrop_next    = odrop_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = top_val_reg;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cnt_reg < CW'(CAPACITY))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[AW-1:0];
                        ram_wdata = value;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        hs_next       = cnt_next;
                        kcnt_next     = cnt_next >> 1;
                        in_build_next = 1'b1;
                        state_next    = S_BUILD_NEXT;
                    end
                end
            end
            S_BUILD_NEXT:
            begin
                if (kcnt_reg == '0)
                begin
                    kcnt_next     = cnt_reg;
                    in_build_next = 1'b0;
                    state_next    = S_EX_NEXT;
                end
                else
                begin
                    idx_next   = kcnt_dec[AW-1:0];
                    kcnt_next  = kcnt_dec;
                    state_next = S_SIFT_RD;
                end
            end
            S_SIFT_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_SIFT_TOP;
            end
            S_SIFT_TOP:
            begin
                top_val_next = ram_rdata;
                state_next   = S_SIFT_L;
            end
            S_SIFT_L:
            begin
                if (left_ok)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = left_w[AW-1:0];
                    state_next = S_SIFT_R;
                end
                else
                begin
                    // leaf reached: drop the sifted value into its slot
                    ram_we     = 1'b1;
                    state_next = in_build_reg ? S_BUILD_NEXT : S_EX_NEXT;
                end
            end
            S_SIFT_R:
            begin
                best_val_next = pick_val;
                best_idx_next = pick_idx;
                ram_re        = 1'b1;
                ram_raddr     = right_w[AW-1:0];
                state_next    = S_SIFT_C;
            end
            S_SIFT_C:
            begin
                ram_we = 1'b1;
                if (pick_idx == idx_reg)
                begin
                    state_next = in_build_reg ? S_BUILD_NEXT : S_EX_NEXT;
                end
                else
                begin
                    // move the larger child up and follow the hole down
                    ram_wdata  = pick_val;
                    idx_next   = pick_idx;
                    state_next = S_SIFT_L;
                end
            end
            S_EX_NEXT:
            begin
                if (kcnt_reg == '0)
                begin
                    ecnt_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = S_EX_R0;
                end
            end
            S_EX_R0:
            begin
                // root goes to the end of the heap; the read returns the old end entry
                ram_re     = 1'b1;
                ram_raddr  = kcnt_dec[AW-1:0];
                ram_we     = 1'b1;
                ram_waddr  = kcnt_dec[AW-1:0];
                ram_wdata  = ram_rdata;
                state_next = S_EX_R1;
            end
            S_EX_R1:
            begin
                top_val_next = ram_rdata;
                hs_next      = kcnt_dec;
                idx_next     = '0;
                kcnt_next    = kcnt_dec;
                state_next   = S_SIFT_L;
            end
            S_EMIT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ecnt_reg[AW-1:0];
                ovld_next  = 1'b1;
                olast_next = (ecnt_reg == cnt_reg - CW'(1));
                odrop_next = ovf_reg;
                if (ecnt_reg == cnt_reg - CW'(1))
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    hs_next    = '0;
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ecnt_next = ecnt_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            hs_reg       <= '0;
            idx_reg      <= '0;
            kcnt_reg     <= '0;
            in_build_reg <= 1'b0;
            ecnt_reg     <= '0;
            ovld_reg     <= 1'b0;
            olast_reg    <= 1'b0;
            odrop_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            hs_reg       <= hs_next;
            idx_reg      <= idx_next;
            kcnt_reg     <= kcnt_next;
            in_build_reg <= in_build_next;
            ecnt_reg     <= ecnt_next;
            ovld_reg     <= ovld_next;
            olast_reg    <= olast_next;
            odrop_reg    <= odrop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        top_val_reg  <= top_val_next;
        best_val_reg <= best_val_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign out_valid    = ovld_reg;
    assign sorted_value = ram_rdata;
    assign end_of_batch = olast_reg;
    assign dropped      = odrop_reg;

    `HSA_ASSERT(a_cnt_cap, cnt_reg <= CW'(CAPACITY))
    `HSA_ASSERT_IMP(a_more_pending, out_valid && !end_of_batch, busy)
    `HSA_ASSERT_NEXT(a_batch_closed, out_valid && end_of_batch, !out_valid)
    `HSA_ASSERT_NEXT(a_last_starts_sort, accept && is_last, busy && !out_valid)

endmodule

// File: rtl/hsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/hsa_pick.sv
// Shared signed compare unit: keeps the larger of the current best and a candidate.
module hsa_pick #(
    parameter int AW = 6
) (
    input  hsa_pkg::value_t cand_val,
    input  logic [AW-1:0]   cand_idx,
    input  logic            cand_ok,
    input  hsa_pkg::value_t best_val,
    input  logic [AW-1:0]   best_idx,
    output hsa_pkg::value_t pick_val,
    output logic [AW-1:0]   pick_idx
);

    logic take;

    // only a strictly larger child wins, so ties stay in place
    assign take     = cand_ok && (cand_val > best_val);
    assign pick_val = take ? cand_val : best_val;
    assign pick_idx = take ? cand_idx : best_idx;

endmodule
